// ----- rtl/gpf_pkg.sv -----
// Shared types and constants for the Goldbach partition finder.
package gpf_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int NUM_W       = 8;

    // Classified request as it travels from front end to scanner
    typedef struct packed {
        logic [NUM_W-1:0] n;
        logic             ok;
    } gpf_item_t;

    // Queue status seen by the front end and scanner
    typedef struct packed {
        logic full;
        logic empty;
    } gpf_q_stat_t;

endpackage

// ----- rtl/gpf_front.sv -----
// Front end: request acceptance and range/parity classification.
module gpf_front
    import gpf_pkg::*;
#(
    parameter int LIMIT = 128
)
(
    input  logic             start,
    input  logic [NUM_W-1:0] even_number,
    input  logic             table_ready,
    input  gpf_q_stat_t      q_stat,
    output logic             busy,
    output logic             push,
    output gpf_item_t        push_item
);

    assign busy = !table_ready || q_stat.full;
    assign push = start && !busy;

    always_comb
    begin
        push_item.n  = even_number;
        push_item.ok = (even_number >= NUM_W'(4)) && !even_number[0]
                       && (32'(even_number) <= LIMIT);
    end

endmodule

// ----- rtl/gpf_queue.sv -----
// Two-entry queue between the front end and the scanner.
module gpf_queue
    import gpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  gpf_item_t   push_item,
    input  logic        pop,
    output gpf_item_t   head,
    output gpf_q_stat_t q_stat
);

    gpf_item_t  entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] cnt_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == 2'd2);
    assign q_stat.empty = (cnt_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/gpf_table.sv -----
// Prime-flag memory with the post-reset sieve sequencer and two read ports.
module gpf_table
#(
    parameter int LIMIT = 128,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] addr_a,
    input  logic [AW-1:0] addr_b,
    output logic          flag_a,
    output logic          flag_b,
    output logic          ready
);

    // only entries up to 255 are reachable through an 8-bit request
    localparam int TBL   = (LIMIT < 255) ? LIMIT : 255;
    localparam int DEPTH = TBL + 1;
    localparam logic [AW:0] TBL_W = (AW+1)'(TBL);

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_CROSS = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic          mem [DEPTH];
    logic [1:0]    state_reg, state_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW:0]   sq_reg, sq_next;
    logic [AW:0]   m_reg, m_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic [AW:0]   m_step;
    logic [AW:0]   sq_step;
    logic          rd_a_reg, rd_b_reg;

    assign ready  = (state_reg == ST_DONE);
    assign flag_a = rd_a_reg;
    assign flag_b = rd_b_reg;

    assign m_step  = m_reg + {1'b0, k_reg};
    assign sq_step = sq_reg + {k_reg, 1'b1};   // (k+1)^2 = k^2 + 2k + 1

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        sq_next    = sq_reg;
        m_next     = m_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        wr_data    = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[AW-1:0];
                wr_data  = (cnt_reg >= (AW+1)'(2));
                cnt_next = cnt_reg + (AW+1)'(1);
                if (cnt_reg == TBL_W)
                begin
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                // strike multiples of k from k*k upward
                wr_en   = 1'b1;
                wr_addr = m_reg[AW-1:0];
                wr_data = 1'b0;
                if (m_step <= TBL_W)
                begin
                    m_next = m_step;
                end
                else if (sq_step > TBL_W)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next  = k_reg + AW'(1);
                    sq_next = sq_step;
                    m_next  = sq_step;
                end
            end
            ST_DONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            k_reg     <= AW'(2);
            sq_reg    <= (AW+1)'(4);
            m_reg     <= (AW+1)'(4);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            sq_reg    <= sq_next;
            m_reg     <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

endmodule

// ----- rtl/gpf_back.sv -----
// Scanner: walks candidate primes for one request and issues the results.
module gpf_back
    import gpf_pkg::*;
#(
    parameter int AW = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  gpf_q_stat_t      q_stat,
    input  gpf_item_t        head,
    output logic             pop,
    output logic [AW-1:0]    addr_a,
    output logic [AW-1:0]    addr_b,
    input  logic             flag_a,
    input  logic             flag_b,
    output logic             result_strobe,
    output logic [NUM_W-1:0] smaller_prime,
    output logic [NUM_W-1:0] larger_prime,
    output logic             found,
    output logic             last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic [NUM_W-1:0] half_reg, half_next;
    logic [NUM_W-1:0] p_reg, p_next;
    logic             issue_reg, issue_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [NUM_W-1:0] chk_p_reg, chk_p_next;
    logic [NUM_W-1:0] chk_q_reg, chk_q_next;
    logic             chk_end_reg, chk_end_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [NUM_W-1:0] hold_p_reg, hold_p_next;
    logic [NUM_W-1:0] hold_q_reg, hold_q_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             strobe_reg, strobe_next;
    logic [NUM_W-1:0] small_reg, small_next;
    logic [NUM_W-1:0] large_reg, large_next;
    logic             found_reg, found_next;
    logic             last_reg, last_next;
    logic [NUM_W-1:0] q_cur;

    assign q_cur  = n_reg - p_reg;
    assign addr_a = p_reg[AW-1:0];
    assign addr_b = q_cur[AW-1:0];

    assign result_strobe = strobe_reg;
    assign smaller_prime = small_reg;
    assign larger_prime  = large_reg;
    assign found         = found_reg;
    assign last          = last_reg;

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        half_next       = half_reg;
        p_next          = p_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_p_next      = chk_p_reg;
        chk_q_next      = chk_q_reg;
        chk_end_next    = chk_end_reg;
        hold_valid_next = hold_valid_reg;
        hold_p_next     = hold_p_reg;
        hold_q_next     = hold_q_reg;
        count_next      = count_reg;
        strobe_next     = 1'b0;
        small_next      = small_reg;
        large_next      = large_reg;
        found_next      = found_reg;
        last_next       = last_reg;
        pop             = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop             = 1'b1;
                    n_next          = head.n;
                    half_next       = head.n >> 1;
                    p_next          = NUM_W'(2);
                    hold_valid_next = 1'b0;
                    count_next      = '0;
                    issue_next      = head.ok;
                    state_next      = head.ok ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                // read issue; the registered flags come back in the next cycle
                if (issue_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_p_next     = p_reg;
                    chk_q_next     = q_cur;
                    chk_end_next   = (p_reg == half_reg);
                    p_next         = p_reg + NUM_W'(1);
                    if (p_reg == half_reg)
                    begin
                        issue_next = 1'b0;
                    end
                end
                // a pair is held back until we know whether it is the final one
                if (chk_valid_reg)
                begin
                    if (flag_a && flag_b)
                    begin
                        if (hold_valid_reg)
                        begin
                            strobe_next = 1'b1;
                            small_next  = hold_p_reg;
                            large_next  = hold_q_reg;
                            found_next  = 1'b1;
                            last_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_p_next     = chk_p_reg;
                        hold_q_next     = chk_q_reg;
                        count_next      = count_reg + CNT_W'(1);
                        if (count_reg == CNT_W'(MAX_RESULTS - 1))
                        begin
                            issue_next = 1'b0;
                            state_next = ST_FIN;
                        end
                    end
                    if (chk_end_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                strobe_next = 1'b1;
                small_next  = hold_valid_reg ? hold_p_reg : '0;
                large_next  = hold_valid_reg ? hold_q_reg : '0;
                found_next  = hold_valid_reg;
                last_next   = 1'b1;
                issue_next  = 1'b0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_reg      <= 1'b0;
            chk_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            chk_valid_reg  <= chk_valid_next;
            hold_valid_reg <= hold_valid_next;
            count_reg      <= count_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        half_reg    <= half_next;
        p_reg       <= p_next;
        chk_p_reg   <= chk_p_next;
        chk_q_reg   <= chk_q_next;
        chk_end_reg <= chk_end_next;
        hold_p_reg  <= hold_p_next;
        hold_q_reg  <= hold_q_next;
        small_reg   <= small_next;
        large_reg   <= large_next;
        found_reg   <= found_next;
        last_reg    <= last_next;
    end

endmodule

// ----- rtl/goldbach_partition_finder.sv -----
// Goldbach partition finder: splits an even number into pairs of primes.
//
// Requests: drive even_number with start high; the request is taken on a
// rising edge where start is high and busy is low. Results leave on
// smaller_prime / larger_prime / found / last, each valid for exactly one
// cycle while result_strobe is high. A request gives one result per prime
// pair p <= n/2 (rising p, at most 16), the final one with last set; an odd
// number, one below 4, one above LIMIT, or one with no pair gives a single
// result with found low and both primes zero.
// After reset the prime table is built by a sieve sequencer: it initializes
// entries 0 to min(LIMIT,255), then strikes multiples; busy stays high
// until it is done. A two-entry queue sits between acceptance and the scanner,
// so up to two requests can be taken while one is being scanned.
// Per request the scanner pops the request, issues one lookup pair per
// candidate through the two-port flag memory, waits for the last lookup to
// return and makes one final issue, stopping early at 16 pairs; invalid
// requests go from the pop straight to the final issue. Results cannot be
// held off.
module goldbach_partition_finder
    import gpf_pkg::*;
#(
    parameter int LIMIT = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] even_number,
    output logic             busy,
    output logic             result_strobe,
    output logic [NUM_W-1:0] smaller_prime,
    output logic [NUM_W-1:0] larger_prime,
    output logic             found,
    output logic             last
);

    localparam int TBL = (LIMIT < 255) ? LIMIT : 255;
    localparam int AW  = $clog2(TBL + 1);

    logic          table_ready;
    gpf_q_stat_t   q_stat;
    logic          push;
    gpf_item_t     push_item;
    logic          pop;
    gpf_item_t     head;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          flag_a;
    logic          flag_b;

    gpf_front #(
        .LIMIT (LIMIT)
    ) u_front (
        .start       (start),
        .even_number (even_number),
        .table_ready (table_ready),
        .q_stat      (q_stat),
        .busy        (busy),
        .push        (push),
        .push_item   (push_item)
    );

    gpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    gpf_table #(
        .LIMIT (LIMIT),
        .AW    (AW)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .flag_a (flag_a),
        .flag_b (flag_b),
        .ready  (table_ready)
    );

    gpf_back #(
        .AW (AW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (pop),
        .addr_a        (addr_a),
        .addr_b        (addr_b),
        .flag_a        (flag_a),
        .flag_b        (flag_b),
        .result_strobe (result_strobe),
        .smaller_prime (smaller_prime),
        .larger_prime  (larger_prime),
        .found         (found),
        .last          (last)
    );

endmodule

// ----- tb/gpf_checker.sv -----
// Checker for the Goldbach partition finder: predicts prime pairs and compares results.
`timescale 1ns / 100ps

module gpf_checker
    import gpf_pkg::*;
#(
    parameter int LIMIT = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [NUM_W-1:0] even_number,
    input  logic             result_strobe,
    input  logic [NUM_W-1:0] smaller_prime,
    input  logic [NUM_W-1:0] larger_prime,
    input  logic             found,
    input  logic             last,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [NUM_W-1:0] lo_prime;
        logic [NUM_W-1:0] hi_prime;
        logic             found;
        logic             last;
    } pair_result_t;

    bit           is_prime [0:LIMIT];
    pair_result_t expected_pairs [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        for (int k = 0; k <= LIMIT; k++)
            is_prime[k] = (k >= 2);
        for (int k = 2; k * k <= LIMIT; k++)
            if (is_prime[k])
                for (int m = k * k; m <= LIMIT; m += k)
                    is_prime[m] = 0;
    end

    // Queue the pairs one transaction with number n must produce.
    function automatic void split_into_primes(input logic [NUM_W-1:0] n);
        int           count;
        int           value;
        pair_result_t pair;
        count = 0;
        value = int'(n);
        if (value >= 4 && value[0] == 1'b0 && value <= LIMIT)
        begin
            for (int p = 2; p <= value / 2 && count < MAX_RESULTS; p++)
            begin
                if (is_prime[p] && is_prime[value - p])
                begin
                    pair.lo_prime = p[NUM_W-1:0];
                    pair.hi_prime = NUM_W'(value - p);
                    pair.found    = 1'b1;
                    pair.last     = (count == MAX_RESULTS - 1);
                    expected_pairs = {expected_pairs, pair};
                    count++;
                end
            end
        end
        if (count == 0)
        begin
            pair = '{lo_prime: '0, hi_prime: '0, found: 1'b0, last: 1'b1};
            expected_pairs = {expected_pairs, pair};
        end
        else
        begin
            // final pair of this transaction carries last
            pair = expected_pairs[$];
            pair.last = 1'b1;
            expected_pairs[$] = pair;
        end
    endfunction

    always @(posedge clk)
    begin
        pair_result_t want;
        pair_result_t got;
        if (rst_n)
        begin
            // results first: a transaction taken this edge cannot answer in the same cycle
            if (result_strobe)
            begin
                got = '{lo_prime: smaller_prime, hi_prime: larger_prime,
                        found: found, last: last};
                if (expected_pairs.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result p=%0d q=%0d found=%b last=%b",
                                 $realtime, smaller_prime, larger_prime, found, last);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp p=%0d q=%0d found=%b last=%b, got p=%0d q=%0d found=%b last=%b",
                                     $realtime, want.lo_prime, want.hi_prime, want.found,
                                     want.last, got.lo_prime, got.hi_prime, got.found,
                                     got.last);
                    end
                end
            end
            if (start && !busy)
                split_into_primes(even_number);
            outstanding <= expected_pairs.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top-level testbench for the Goldbach partition finder: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb
    import gpf_pkg::*;
();

    localparam int LIMIT          = 128;
    localparam int PHASE_ITEMS    = 140;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic [NUM_W-1:0] even_number;
    logic             busy;
    logic             result_strobe;
    logic [NUM_W-1:0] smaller_prime;
    logic [NUM_W-1:0] larger_prime;
    logic             found;
    logic             last;
    int               mismatches;
    int               outstanding;
    int               quiet_cycles;

    goldbach_partition_finder #(.LIMIT(LIMIT)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .even_number   (even_number),
        .busy          (busy),
        .result_strobe (result_strobe),
        .smaller_prime (smaller_prime),
        .larger_prime  (larger_prime),
        .found         (found),
        .last          (last)
    );

    gpf_checker #(.LIMIT(LIMIT)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .even_number   (even_number),
        .result_strobe (result_strobe),
        .smaller_prime (smaller_prime),
        .larger_prime  (larger_prime),
        .found         (found),
        .last          (last),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        even_number = '0;
    end

    always #5 clk = ~clk;

    // Watchdog: cycles with neither a request nor a result taken.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial quiet_cycles = 0;

    // Hold start for one transaction until it is taken, after a random gap.
    task automatic send_number(input logic [NUM_W-1:0] n, input int idle_pct);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        even_number <= n;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [NUM_W-1:0] pick_number();
        int r;
        r = $urandom_range(99, 0);
        if (r < 80)
            return NUM_W'(2 * $urandom_range(LIMIT / 2, 2));
        else if (r < 86)
            return NUM_W'($urandom_range(255, 0) | 1);
        else if (r < 90)
            return NUM_W'($urandom_range(3, 0));
        else
            return NUM_W'($urandom_range(255, LIMIT + 1));
    endfunction

    initial
    begin
        logic [NUM_W-1:0] directed [];
        int               idle_pct [3];

        directed = {8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
                    8'd8, 8'd10, 8'd12, 8'd64, 8'd98, 8'd120,
                    8'd126, 8'd127, 8'd128, 8'd129, 8'd130,
                    8'd200, 8'd254, 8'd255, 8'd85, 8'd170};
        idle_pct = '{36, 61, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // odd, tiny, above-table and pair-rich numbers, plus bit extremes
        foreach (directed[i])
            send_number(directed[i], idle_pct[0]);

        for (int phase = 0; phase < 3; phase++)
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_number(pick_number(), idle_pct[phase]);

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gpf_pkg.sv
rtl/gpf_front.sv
rtl/gpf_queue.sv
rtl/gpf_table.sv
rtl/gpf_back.sv
rtl/goldbach_partition_finder.sv
tb/gpf_checker.sv
tb/tb.sv
